### rtl/core/tlvp_pkg.sv
// shared types, constants and helpers for the tlv record parser
// no dependencies; imported by every module of the block
`timescale 1ns / 1ps

package tlvp_pkg;

    // value bytes kept per record, capped at the width of value_word
    localparam int VALUE_BYTES = 4;
    localparam int KEEP_BYTES  = (VALUE_BYTES > 4) ? 4 : VALUE_BYTES;

    localparam int HDR_BYTES   = 4;
    localparam int CNT_W       = 3;
    localparam logic [CNT_W-1:0] HDR_CNT  = CNT_W'(HDR_BYTES);
    localparam logic [CNT_W-1:0] KEEP_CNT = CNT_W'(KEEP_BYTES);

    localparam logic [15:0] TYPE_AMP  = 16'h0000;
    localparam logic [15:0] TYPE_XCVR = 16'h0001;

    // output stream packing
    localparam int TDATA_W = 72;
    localparam int TUSER_W = 2;

    typedef enum logic [1:0] {
        STATUS_AMP       = 2'd0,
        STATUS_XCVR      = 2'd1,
        STATUS_UNKNOWN   = 2'd2,
        STATUS_TRUNCATED = 2'd3
    } status_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_datagram;
    } tlvp_byte_t;

    typedef struct packed {
        status_t     record_status;
        logic [15:0] record_type;
        logic [15:0] record_length;
        logic [31:0] value_word;
        logic [2:0]  value_bytes_held;
    } tlvp_result_t;

    function automatic status_t class_of(input logic [15:0] rec_type);
        status_t st;
        if (rec_type == TYPE_AMP)
            st = STATUS_AMP;
        else if (rec_type == TYPE_XCVR)
            st = STATUS_XCVR;
        else
            st = STATUS_UNKNOWN;
        return st;
    endfunction

endpackage

### rtl/core/tlvp_in_stage.sv
// input register for the byte stream
// depends on tlvp_pkg
`timescale 1ns / 1ps

module tlvp_in_stage
    import tlvp_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  tlvp_byte_t in_item,
    output logic       hold_valid,
    output tlvp_byte_t hold_item,
    input  logic       advance
);

    logic       valid_reg;
    logic       valid_next;
    tlvp_byte_t item_reg;

    // take a new transaction when empty or when the held one moves on
    assign in_ready   = !valid_reg || advance;
    assign valid_next = in_ready ? in_valid : valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            item_reg <= in_item;
        end
    end

    assign hold_valid = valid_reg;
    assign hold_item  = item_reg;

endmodule

### rtl/core/tlvp_core.sv
// record state and next-state logic: header assembly, value capture, truncation
// depends on tlvp_pkg
`timescale 1ns / 1ps

module tlvp_core
    import tlvp_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         step,
    input  tlvp_byte_t   item,
    output logic         produce,
    output tlvp_result_t result
);

    logic [CNT_W-1:0] hc_reg, hc_next;
    logic [31:0]      hs_reg, hs_next;
    logic [15:0]      vr_reg, vr_next;
    logic [31:0]      vs_reg, vs_next;
    logic [CNT_W-1:0] seen_reg, seen_next;

    always_comb
    begin
        hc_next   = hc_reg;
        hs_next   = hs_reg;
        vr_next   = vr_reg;
        vs_next   = vs_reg;
        seen_next = seen_reg;
        produce   = 1'b0;
        result    = '0;

        if (hc_reg < HDR_CNT)
        begin
            hs_next = {hs_reg[23:0], item.data_byte};
            hc_next = hc_reg + 1'b1;
            if (hc_next == HDR_CNT)
            begin
                vs_next   = '0;
                seen_next = '0;
                vr_next   = hs_next[15:0];
                if (hs_next[15:0] == 16'd0)
                begin
                    produce                 = 1'b1;
                    result.record_status    = class_of(hs_next[31:16]);
                    result.record_type      = hs_next[31:16];
                    hc_next                 = '0;
                    hs_next                 = '0;
                end
            end
        end
        else
        begin
            if (seen_reg < KEEP_CNT)
            begin
                for (int i = 0; i < KEEP_BYTES; i++)
                begin
                    if (seen_reg == CNT_W'(i))
                    begin
                        vs_next[31-8*i -: 8] = item.data_byte;
                    end
                end
                seen_next = seen_reg + 1'b1;
            end
            if (vr_reg != 16'd0)
            begin
                vr_next = vr_reg - 1'b1;
            end
            if (vr_next == 16'd0)
            begin
                produce                 = 1'b1;
                result.record_status    = class_of(hs_reg[31:16]);
                result.record_type      = hs_reg[31:16];
                result.record_length    = hs_reg[15:0];
                result.value_word       = vs_next;
                result.value_bytes_held = seen_next;
                hc_next                 = '0;
                hs_next                 = '0;
                vs_next                 = '0;
                seen_next               = '0;
            end
        end

        if (item.end_of_datagram)
        begin
            if (!produce && hc_next != '0)
            begin
                produce              = 1'b1;
                result.record_status = STATUS_TRUNCATED;
                // header incomplete: everything else reads as zero
                if (hc_next == HDR_CNT)
                begin
                    result.record_type      = hs_next[31:16];
                    result.record_length    = hs_next[15:0];
                    result.value_word       = vs_next;
                    result.value_bytes_held = seen_next;
                end
            end
            hc_next   = '0;
            hs_next   = '0;
            vr_next   = '0;
            vs_next   = '0;
            seen_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hc_reg   <= '0;
            hs_reg   <= '0;
            vr_reg   <= '0;
            vs_reg   <= '0;
            seen_reg <= '0;
        end
        else if (step)
        begin
            hc_reg   <= hc_next;
            hs_reg   <= hs_next;
            vr_reg   <= vr_next;
            vs_reg   <= vs_next;
            seen_reg <= seen_next;
        end
    end

    a_hc_range: assert property (@(posedge clk) disable iff (!rst_n)
        hc_reg <= HDR_CNT)
        else $error("header count beyond header length");

    a_header_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (hc_reg < HDR_CNT) |-> (seen_reg == '0 && vs_reg == '0))
        else $error("value capture not clear during header phase");

    a_seen_cap: assert property (@(posedge clk) disable iff (!rst_n)
        seen_reg <= KEEP_CNT)
        else $error("kept value byte count exceeds limit");

    a_eod_restart: assert property (@(posedge clk) disable iff (!rst_n)
        (step && item.end_of_datagram) |=> (hc_reg == '0 && vr_reg == 16'd0))
        else $error("state not cleared after datagram end");

endmodule

### rtl/core/tlvp_out_stage.sv
// result register feeding the output stream
// depends on tlvp_pkg
`timescale 1ns / 1ps

module tlvp_out_stage
    import tlvp_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         load,
    input  tlvp_result_t load_result,
    output logic         free,
    output logic         out_valid,
    input  logic         out_ready,
    output tlvp_result_t out_result
);

    logic         valid_reg;
    logic         valid_next;
    tlvp_result_t result_reg;

    assign free = !valid_reg || out_ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (out_ready)
        begin
            valid_next = 1'b0;
        end
        if (load)
        begin
            valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            result_reg <= load_result;
        end
    end

    assign out_valid  = valid_reg;
    assign out_result = result_reg;

endmodule

### rtl/core/tlv_record_parser.sv
// tlv record parser: splits a byte stream into type-length-value records
// m_axis_tvalid rises once the closing byte has passed the input and result registers
// throughput: 1 byte per cycle while m_axis_tready is high; parse state advances once per byte
// reset (rst_n, async, active low) empties both registers and clears the record state
// depends on tlvp_pkg, tlvp_in_stage, tlvp_core, tlvp_out_stage
`timescale 1ns / 1ps

module tlv_record_parser
    import tlvp_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               s_axis_tvalid,
    output logic               s_axis_tready,
    input  logic [7:0]         s_axis_tdata,   // data_byte
    input  logic               s_axis_tlast,   // end_of_datagram
    output logic               m_axis_tvalid,
    input  logic               m_axis_tready,
    output logic [TDATA_W-1:0] m_axis_tdata,   // record_type, record_length, value_word,
                                               // value_bytes_held, zero pad
    output logic [TUSER_W-1:0] m_axis_tuser    // record_status
);

    tlvp_byte_t   in_item;
    tlvp_byte_t   hold_item;
    logic         hold_valid;
    logic         advance;
    logic         out_free;
    logic         produce;
    tlvp_result_t core_result;
    tlvp_result_t out_result;

    assign in_item.data_byte       = s_axis_tdata;
    assign in_item.end_of_datagram = s_axis_tlast;

    assign advance = hold_valid && out_free;

    tlvp_in_stage u_in (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_axis_tvalid),
        .in_ready   (s_axis_tready),
        .in_item    (in_item),
        .hold_valid (hold_valid),
        .hold_item  (hold_item),
        .advance    (advance)
    );

    tlvp_core u_core (
        .clk     (clk),
        .rst_n   (rst_n),
        .step    (advance),
        .item    (hold_item),
        .produce (produce),
        .result  (core_result)
    );

    tlvp_out_stage u_out (
        .clk         (clk),
        .rst_n       (rst_n),
        .load        (advance && produce),
        .load_result (core_result),
        .free        (out_free),
        .out_valid   (m_axis_tvalid),
        .out_ready   (m_axis_tready),
        .out_result  (out_result)
    );

    assign m_axis_tdata = {5'b0, out_result.value_bytes_held, out_result.value_word,
                           out_result.record_length, out_result.record_type};
    assign m_axis_tuser = out_result.record_status;

endmodule

### bench/tlvp_record_checker.sv
// record checker for the tlv record parser: watches both streams, predicts each record
// result from the accepted bytes and compares it with what the parser hands out
// depends on tlvp_pkg
`timescale 1ns / 1ps

module tlvp_record_checker
    import tlvp_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               s_axis_tvalid,
    input  logic               s_axis_tready,
    input  logic [7:0]         s_axis_tdata,    // data_byte
    input  logic               s_axis_tlast,    // end_of_datagram
    input  logic               m_axis_tvalid,
    input  logic               m_axis_tready,
    input  logic [TDATA_W-1:0] m_axis_tdata,    // record_type, record_length, value_word,
                                                // value_bytes_held, zero pad
    input  logic [TUSER_W-1:0] m_axis_tuser,    // record_status
    output int                 fail_count,
    output int                 records_pending
);

    // parse state mirrored from the accepted byte stream
    logic [CNT_W-1:0] hdr_taken;
    logic [31:0]      hdr_bits;
    logic [15:0]      value_left;
    logic [31:0]      value_kept;
    logic [CNT_W-1:0] value_count;

    tlvp_result_t expected_records[$];

    function automatic status_t type_class(input logic [15:0] rec_type);
        status_t st;
        case (rec_type)
            TYPE_AMP:  st = STATUS_AMP;
            TYPE_XCVR: st = STATUS_XCVR;
            default:   st = STATUS_UNKNOWN;
        endcase
        return st;
    endfunction

    function automatic void clear_parse();
        hdr_taken   = '0;
        hdr_bits    = '0;
        value_left  = '0;
        value_kept  = '0;
        value_count = '0;
    endfunction

    // advances the mirrored parse state by one byte; returns 1 when a record result is due
    function automatic bit parse_byte(input logic [7:0] b, input logic last,
                                      output tlvp_result_t rec);
        bit done;
        done = 1'b0;
        rec  = '0;
        if (hdr_taken < HDR_CNT) begin
            hdr_bits  = {hdr_bits[23:0], b};
            hdr_taken = hdr_taken + 1'b1;
            if (hdr_taken == HDR_CNT) begin
                value_kept  = '0;
                value_count = '0;
                value_left  = hdr_bits[15:0];
                if (value_left == 16'd0) begin
                    rec.record_status = type_class(hdr_bits[31:16]);
                    rec.record_type   = hdr_bits[31:16];
                    done      = 1'b1;
                    hdr_taken = '0;
                    hdr_bits  = '0;
                end
            end
        end
        else begin
            if (value_count < KEEP_CNT) begin
                value_kept[31 - 8 * int'(value_count) -: 8] = b;
                value_count = value_count + 1'b1;
            end
            if (value_left != 16'd0)
                value_left = value_left - 16'd1;
            if (value_left == 16'd0) begin
                rec.record_status    = type_class(hdr_bits[31:16]);
                rec.record_type      = hdr_bits[31:16];
                rec.record_length    = hdr_bits[15:0];
                rec.value_word       = value_kept;
                rec.value_bytes_held = value_count;
                done = 1'b1;
                clear_parse();
            end
        end
        if (last) begin
            // datagram ended inside a record
            if (!done && hdr_taken != '0) begin
                rec.record_status = STATUS_TRUNCATED;
                if (hdr_taken == HDR_CNT) begin
                    rec.record_type      = hdr_bits[31:16];
                    rec.record_length    = hdr_bits[15:0];
                    rec.value_word       = value_kept;
                    rec.value_bytes_held = value_count;
                end
                done = 1'b1;
            end
            clear_parse();
        end
        return done;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        tlvp_result_t predicted;
        tlvp_result_t want;
        tlvp_result_t got;
        if (!rst_n) begin
            clear_parse();
            expected_records.delete();
            fail_count      = 0;
            records_pending <= 0;
        end
        else begin
            if (s_axis_tvalid && s_axis_tready) begin
                if (parse_byte(s_axis_tdata, s_axis_tlast, predicted))
                    expected_records.push_back(predicted);
            end
            if (m_axis_tvalid && m_axis_tready) begin
                got.record_status    = status_t'(m_axis_tuser[1:0]);
                got.record_type      = m_axis_tdata[15:0];
                got.record_length    = m_axis_tdata[31:16];
                got.value_word       = m_axis_tdata[63:32];
                got.value_bytes_held = m_axis_tdata[66:64];
                if (expected_records.size() == 0) begin
                    $error("unexpected record transaction: status %0d type %h",
                           got.record_status, got.record_type);
                    fail_count++;
                end
                else begin
                    want = expected_records.pop_front();
                    if (got.record_status !== want.record_status) begin
                        $error("record_status expected %0d actual %0d",
                               want.record_status, got.record_status);
                        fail_count++;
                    end
                    if (got.record_type !== want.record_type) begin
                        $error("record_type expected %h actual %h",
                               want.record_type, got.record_type);
                        fail_count++;
                    end
                    if (got.record_length !== want.record_length) begin
                        $error("record_length expected %h actual %h",
                               want.record_length, got.record_length);
                        fail_count++;
                    end
                    if (got.value_word !== want.value_word) begin
                        $error("value_word expected %h actual %h",
                               want.value_word, got.value_word);
                        fail_count++;
                    end
                    if (got.value_bytes_held !== want.value_bytes_held) begin
                        $error("value_bytes_held expected %0d actual %0d",
                               want.value_bytes_held, got.value_bytes_held);
                        fail_count++;
                    end
                end
            end
            records_pending <= expected_records.size();
        end
    end

endmodule

### bench/tb_top.sv
// top of the tlv record parser bench: clock, reset, datagram stimulus with random gaps,
// random back-pressure, idle watchdog and the verdict
// depends on tlvp_pkg, tlv_record_parser and tlvp_record_checker
`timescale 1ns / 1ps

module tb_top
    import tlvp_pkg::*;
();

    localparam int BYTE_TARGET = 1100;
    localparam int IDLE_LIMIT  = 1000;
    localparam int TAIL_CYCLES = 20;

    logic               clk           = 1'b0;
    logic               rst_n         = 1'b0;
    logic               s_axis_tvalid = 1'b0;
    logic               s_axis_tready;
    logic [7:0]         s_axis_tdata  = '0;
    logic               s_axis_tlast  = 1'b0;
    logic               m_axis_tvalid;
    logic               m_axis_tready = 1'b0;
    logic [TDATA_W-1:0] m_axis_tdata;
    logic [TUSER_W-1:0] m_axis_tuser;

    int fail_count;
    int records_pending;
    int bytes_sent = 0;
    int idle_cycles = 0;
    bit steady_run = 1'b0;

    logic [7:0] datagram[$];

    tlv_record_parser i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    tlvp_record_checker i_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .s_axis_tvalid   (s_axis_tvalid),
        .s_axis_tready   (s_axis_tready),
        .s_axis_tdata    (s_axis_tdata),
        .s_axis_tlast    (s_axis_tlast),
        .m_axis_tvalid   (m_axis_tvalid),
        .m_axis_tready   (m_axis_tready),
        .m_axis_tdata    (m_axis_tdata),
        .m_axis_tuser    (m_axis_tuser),
        .fail_count      (fail_count),
        .records_pending (records_pending)
    );

    initial
    begin
        forever #1 clk = ~clk;
    end

    // mostly short gaps, a few long ones
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (steady_run || r < 60)
            return 0;
        else if (r < 92)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 30);
    endfunction

    task automatic push_byte(input logic [7:0] b, input logic last);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tlast  <= last;
        @(posedge clk);
        while (!s_axis_tready) @(posedge clk);
        bytes_sent++;
    endtask

    task automatic send_datagram();
        for (int i = 0; i < datagram.size(); i++)
            push_byte(datagram[i], i == datagram.size() - 1);
        datagram.delete();
    endtask

    // hold the sender until every predicted record has come out
    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (records_pending != 0) @(posedge clk);
    endtask

    task automatic add_header(input logic [15:0] rec_type, input logic [15:0] rec_len);
        datagram.push_back(rec_type[15:8]);
        datagram.push_back(rec_type[7:0]);
        datagram.push_back(rec_len[15:8]);
        datagram.push_back(rec_len[7:0]);
    endtask

    function automatic logic [15:0] random_type();
        int sel;
        sel = $urandom_range(0, 9);
        if (sel < 3)
            return TYPE_AMP;
        else if (sel < 6)
            return TYPE_XCVR;
        else
            return 16'($urandom);
    endfunction

    task automatic build_random_datagram();
        int n_rec;
        int kind;
        int r;
        int shown;
        int keep;
        int base;
        logic [15:0] rec_len;
        n_rec = $urandom_range(0, 3);
        kind  = $urandom_range(0, 9);
        if (kind < 7 && n_rec == 0)
            n_rec = 1;
        for (int k = 0; k < n_rec; k++)
        begin
            r = $urandom_range(0, 99);
            if (r < 10)
                rec_len = 16'd0;
            else if (r < 85)
                rec_len = 16'($urandom_range(1, 8));
            else
                rec_len = 16'($urandom_range(9, 24));
            add_header(random_type(), rec_len);
            repeat (rec_len) datagram.push_back(8'($urandom));
        end
        if (kind == 7 || kind == 8)
        begin
            // record cut short by the end of the datagram, header or value phase
            rec_len = ($urandom_range(0, 1) == 0) ? 16'($urandom_range(0, 6))
                                                  : 16'($urandom_range(7, 65535));
            shown = 4 + ((rec_len > 16'd6) ? 6 : int'(rec_len));
            keep  = (rec_len > 16'd6) ? $urandom_range(1, shown)
                                      : $urandom_range(1, shown - 1);
            base  = datagram.size();
            add_header(random_type(), rec_len);
            repeat (shown - 4) datagram.push_back(8'($urandom));
            while (datagram.size() > base + keep) void'(datagram.pop_back());
        end
        else if (kind == 9)
        begin
            // raw noise closing the datagram
            repeat ($urandom_range(1, 12)) datagram.push_back(8'($urandom));
        end
    endtask

    // receiver: random stalls, with occasional long stretches of steady acceptance
    initial
    begin
        int r;
        @(posedge clk);
        forever
        begin
            r = $urandom_range(0, 99);
            m_axis_tready <= 1'b1;
            if (r < 15)
                repeat ($urandom_range(50, 200)) @(posedge clk);
            else
                repeat ($urandom_range(1, 8)) @(posedge clk);
            m_axis_tready <= 1'b0;
            r = $urandom_range(0, 99);
            if (r < 90)
                repeat ($urandom_range(1, 3)) @(posedge clk);
            else
                repeat ($urandom_range(20, 60)) @(posedge clk);
        end
    end

    initial
    begin
        while (idle_cycles < IDLE_LIMIT)
        begin
            @(posedge clk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("Some tests failed");
        $finish;
    end

    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // zero-length amplifier record, datagram ends on its fourth header byte
        add_header(TYPE_AMP, 16'd0);
        send_datagram();
        // transceiver mode record with two value bytes
        add_header(TYPE_XCVR, 16'd2);
        datagram.push_back(8'hA5);
        datagram.push_back(8'h5A);
        send_datagram();
        // unknown type, value longer than what is kept
        add_header(16'hFFFF, 16'd5);
        datagram.push_back(8'h01);
        datagram.push_back(8'h02);
        datagram.push_back(8'h04);
        datagram.push_back(8'h08);
        datagram.push_back(8'hF0);
        send_datagram();
        // one-byte datagram, truncated inside the header
        datagram.push_back(8'hFF);
        send_datagram();
        // maximum length, truncated inside the value
        add_header(16'hABCD, 16'hFFFF);
        datagram.push_back(8'h80);
        datagram.push_back(8'h7F);
        send_datagram();
        wait_drained();

        while (bytes_sent < BYTE_TARGET)
        begin
            steady_run = ($urandom_range(0, 4) == 0);
            build_random_datagram();
            send_datagram();
            if ($urandom_range(0, 29) == 0)
                wait_drained();
        end

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
